// ===== rtl/scws_pkg.sv =====
// ----------------------------------------------------------------------------
// scws_pkg
// Types and character constants shared by the comment/whitespace stripper.
// ----------------------------------------------------------------------------
package scws_pkg;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       final_char;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       text_done;
		logic       run_end;
	} out_beat_t;

	// one accepted byte's worth of results: up to two bytes, or a bare end marker
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] cnt;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_rd_ctl_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== rtl/scws_front.sv =====
// ----------------------------------------------------------------------------
// scws_front
// Lexer front end: tracks code/string/comment state per byte and builds
// the queue entry holding the bytes that survive.
// ----------------------------------------------------------------------------
module scws_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  scws_pkg::in_beat_t   src_data,
	output scws_pkg::entry_t     ent,
	output logic                 push,
	input  logic                 full
);

	typedef enum logic [1:0] {
		MODE_CODE,
		MODE_STR,
		MODE_LINE,
		MODE_BLOCK
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] quote;
		logic       esc;
		logic       slash;
		logic       star;
		logic       sp;
		logic       blank;
		logic       none;
	} lex_t;

	typedef struct packed {
		lex_t             lx;
		scws_pkg::entry_t ent;
	} work_t;

	localparam lex_t LEX_RST = '{mode: MODE_CODE, quote: 8'h00, esc: 1'b0, slash: 1'b0,
		star: 1'b0, sp: 1'b0, blank: 1'b0, none: 1'b1};

	lex_t  lex_q;
	work_t w;
	logic  accept;

	// append a byte, with the folded space-after-space removal
	function automatic work_t f_emit(work_t wi, logic [7:0] b);
		work_t wo;
		logic  drop;
		wo = wi;
		drop = (b == scws_pkg::CH_SPACE) && wi.lx.sp && !wi.lx.none;
		wo.lx.sp    = (b == scws_pkg::CH_SPACE);
		wo.lx.blank = scws_pkg::is_ws(b);
		wo.lx.none  = 1'b0;
		if (!drop) begin
			if (wi.ent.cnt == 2'd0) begin
				wo.ent.b0 = b;
			end else begin
				wo.ent.b1 = b;
			end
			wo.ent.cnt = wi.ent.cnt + 2'd1;
		end
		return wo;
	endfunction

	function automatic work_t f_handle(work_t wi, logic [7:0] c, logic last);
		work_t wo;
		logic  code;
		wo = wi;
		code = (wi.lx.mode == MODE_CODE);
		if (wi.lx.esc) begin
			wo = f_emit(wo, c);
			wo.lx.esc = 1'b0;
		end else if (c == scws_pkg::CH_BSLASH) begin
			wo = f_emit(wo, c);
			wo.lx.esc = 1'b1;
		end else if (code && c == scws_pkg::CH_SLASH && !last) begin
			wo.lx.slash = 1'b1;
		end else if (code && (c == scws_pkg::CH_DQUOTE || c == scws_pkg::CH_SQUOTE ||
				c == scws_pkg::CH_BTICK)) begin
			wo.lx.mode  = MODE_STR;
			wo.lx.quote = c;
			wo = f_emit(wo, c);
		end else if (wi.lx.mode == MODE_STR && c == wi.lx.quote) begin
			wo.lx.mode = MODE_CODE;
			wo = f_emit(wo, c);
		end else if (code && scws_pkg::is_ws(c)) begin
			if (!wi.lx.none && !wi.lx.blank) begin
				wo = f_emit(wo, scws_pkg::CH_SPACE);
			end
		end else begin
			wo = f_emit(wo, c);
		end
		return wo;
	endfunction

	always_comb begin
		w.lx      = lex_q;
		w.ent     = '0;
		w.ent.last = src_data.final_char;
		if (lex_q.slash) begin
			w.lx.slash = 1'b0;
			if (src_data.in_char == scws_pkg::CH_SLASH) begin
				w.lx.mode = MODE_LINE;
			end else if (src_data.in_char == scws_pkg::CH_STAR) begin
				w.lx.mode = MODE_BLOCK;
				w.lx.star = 1'b0;
			end else begin
				w = f_emit(w, scws_pkg::CH_SLASH);
				w = f_handle(w, src_data.in_char, src_data.final_char);
			end
		end else if (lex_q.mode == MODE_LINE) begin
			if (src_data.in_char == scws_pkg::CH_LF) begin
				w.lx.mode = MODE_CODE;
				w = f_handle(w, src_data.in_char, src_data.final_char);
			end
		end else if (lex_q.mode == MODE_BLOCK) begin
			if (lex_q.star && src_data.in_char == scws_pkg::CH_SLASH) begin
				w.lx.mode = MODE_CODE;
				w.lx.star = 1'b0;
			end else begin
				w.lx.star = (src_data.in_char == scws_pkg::CH_STAR);
			end
		end else begin
			w = f_handle(w, src_data.in_char, src_data.final_char);
		end
	end

	assign src_ready = !full;
	assign accept    = src_valid && src_ready;
	assign ent       = w.ent;
	// a non-final byte that yields nothing leaves no entry
	assign push      = accept && (w.ent.cnt != 2'd0 || src_data.final_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= LEX_RST;
		end else if (accept) begin
			lex_q <= src_data.final_char ? LEX_RST : w.lx;
		end
	end

endmodule

// ===== rtl/scws_queue.sv =====
// ----------------------------------------------------------------------------
// scws_queue
// Short entry queue between the lexer and the beat sequencer.
// ----------------------------------------------------------------------------
module scws_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scws_pkg::entry_t     wr_ent,
	input  logic                 push,
	output scws_pkg::q_wr_ctl_t  wr_ctl,
	output scws_pkg::entry_t     rd_ent,
	input  logic                 pop,
	output scws_pkg::q_rd_ctl_t  rd_ctl
);

	scws_pkg::entry_t             mem_q [scws_pkg::QDEPTH];
	logic [scws_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [scws_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [scws_pkg::QPTR_W:0]    count_q;
	logic                         do_push;
	logic                         do_pop;

	assign wr_ctl.full  = (count_q == (scws_pkg::QPTR_W + 1)'(scws_pkg::QDEPTH));
	assign wr_ctl.push  = do_push;
	assign rd_ctl.empty = (count_q == '0);
	assign rd_ctl.pop   = do_pop;
	assign do_push      = push && !wr_ctl.full;
	assign do_pop       = pop && !rd_ctl.empty;
	assign rd_ent       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/scws_back.sv =====
// ----------------------------------------------------------------------------
// scws_back
// Beat sequencer: splits each queue entry into one or two output beats
// and holds them in the output register.
// ----------------------------------------------------------------------------
module scws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scws_pkg::entry_t     rd_ent,
	input  scws_pkg::q_rd_ctl_t  rd_ctl,
	output logic                 pop,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output scws_pkg::out_beat_t  dst_data
);

	logic                 idx_q;
	logic                 dst_valid_q;
	scws_pkg::out_beat_t  dst_data_q;
	scws_pkg::out_beat_t  beat;
	logic                 load;
	logic                 last_beat;

	always_comb begin
		last_beat       = (rd_ent.cnt != 2'd2) || idx_q;
		beat.out_char   = (rd_ent.cnt == 2'd0) ? 8'h00 : (idx_q ? rd_ent.b1 : rd_ent.b0);
		beat.char_valid = (rd_ent.cnt != 2'd0);
		beat.run_end    = last_beat;
		beat.text_done  = last_beat && rd_ent.last;
	end

	assign load      = !dst_valid_q || dst_ready;
	assign pop       = load && !rd_ctl.empty && last_beat;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	always_ff @(posedge clk) begin
		if (load && !rd_ctl.empty) begin
			dst_data_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 1'b0;
			dst_valid_q <= 1'b0;
		end else if (load) begin
			dst_valid_q <= !rd_ctl.empty;
			if (!rd_ctl.empty) begin
				idx_q <= !last_beat;
			end
		end
	end

endmodule

// ===== rtl/source_comment_whitespace_stripper.sv =====
// ----------------------------------------------------------------------------
// source_comment_whitespace_stripper
// Removes comments and redundant whitespace from a byte stream of script text.
//
//  channel | valid     | ready     | payload   | beat
//  --------+-----------+-----------+-----------+-----------------------------
//  source  | src_valid | src_ready | src_data  | one text byte + final flag
//  result  | dst_valid | dst_ready | dst_data  | one kept byte or end marker
//
// Takes one byte per cycle while the 4-entry queue has room; each byte
// becomes 0, 1 or 2 result beats, sent one per cycle from the output
// register, so bytes that yield two beats bound the sustained rate. Bytes
// pass the queue and the output register in turn. Reset (arst_n) empties
// the queue and returns the lexer to code mode. Either side may stall freely.
// ----------------------------------------------------------------------------
module source_comment_whitespace_stripper (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  scws_pkg::in_beat_t   src_data,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output scws_pkg::out_beat_t  dst_data
);

	scws_pkg::entry_t     wr_ent;
	scws_pkg::entry_t     rd_ent;
	scws_pkg::q_wr_ctl_t  wr_ctl;
	scws_pkg::q_rd_ctl_t  rd_ctl;
	logic                 push;
	logic                 pop;

	scws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.ent       (wr_ent),
		.push      (push),
		.full      (wr_ctl.full)
	);

	scws_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_ent (wr_ent),
		.push   (push),
		.wr_ctl (wr_ctl),
		.rd_ent (rd_ent),
		.pop    (pop),
		.rd_ctl (rd_ctl)
	);

	scws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_ent    (rd_ent),
		.rd_ctl    (rd_ctl),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

endmodule

// ===== rtl/scws_checker.sv =====
// ----------------------------------------------------------------------------
// scws_checker
// Port-level checks on the result stream of the stripper.
// ----------------------------------------------------------------------------
module scws_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dst_valid,
	input  logic                 dst_ready,
	input  scws_pkg::out_beat_t  dst_data
);

	logic dst_acc;
	logic space_beat;

	assign dst_acc    = dst_valid && dst_ready;
	assign space_beat = dst_data.char_valid && (dst_data.out_char == scws_pkg::CH_SPACE);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
		else $error("result beat changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.text_done |-> dst_data.run_end)
		else $error("text_done without run_end");

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.char_valid |->
			dst_data.text_done && dst_data.out_char == 8'h00)
		else $error("bare end marker malformed");

	// back-to-back beats of one text never carry two spaces in a row
	a_no_double_space: assert property (@(posedge clk) disable iff (!arst_n)
		dst_acc && $past(dst_acc) && $past(space_beat) && !$past(dst_data.text_done)
			|-> !space_beat)
		else $error("two adjacent spaces in output");

endmodule

bind source_comment_whitespace_stripper scws_checker u_scws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dst_valid (dst_valid),
	.dst_ready (dst_ready),
	.dst_data  (dst_data)
);
